### src/veh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// veh_pkg
// Shared constants, request and status codes, and sequencer states for the
// variable edge histogram.
// ----------------------------------------------------------------------------
package veh_pkg;

    localparam int MAX_BINS    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_WIDTH = 32;

    localparam int EDGE_IDX_W = $clog2(MAX_BINS + 1);
    localparam int BIN_IDX_W  = $clog2(MAX_BINS);

    // request kinds carried in s_tuser
    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_SAMPLE = 2'd1,
        REQ_READ   = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    // result status carried in m_tuser
    typedef enum logic [1:0] {
        STAT_COUNTED = 2'd0,
        STAT_BELOW   = 2'd1,
        STAT_ABOVE   = 2'd2,
        STAT_DONE    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE
    } state_t;

endpackage

### src/variable_edge_histogram_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_edge_histogram_unit
// Histogram with loadable ascending bin edges and saturating bin counts.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: s_tuser selects load edge, bin a sample, or read a count;
//   s_tdata carries the operands. One result word per load, sample or read
//   leaves on the master stream; request kind 3 is dropped without a result.
//   cfg_we/cfg_wdata set the number of bins in use (write only when idle).
// Timing:
//   Load and read: the result is registered in the cycle after accept.
//   Sample: a single shared compare unit walks the edges one per cycle.
//     Underflow is reported from the compare against edge 0. A hit in bin
//     i walks up to edge i+1, then a count update state writes the count.
//     Overflow is reported past edge n, n = bins_in_use capped at 16.
//   s_tready is high only while the sequencer is idle and the output
//   register is empty or being drained; loads and reads can follow back to
//   back, a word after a sample is taken once its result is registered.
// Reset: all bin counts clear to zero, bins_in_use returns to 16, the output
//   register empties. Edges are undefined until loaded.
// Stall: a result holds in the output register while m_tready is low; no
//   new word is taken until it drains.
// ----------------------------------------------------------------------------
module variable_edge_histogram_unit
    import veh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,   // bins_in_use
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,     // edge_index[4:0], edge_value[36:5],
                                     // sample_value[68:37], read_bin[72:69]
    input  logic [1:0]  s_tuser,     // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,     // bin_index[3:0], bin_count[35:4]
    output logic [1:0]  m_tuser      // status[1:0]
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // input fields
    logic [1:0]                    req_type;
    logic [4:0]                    edge_index;
    logic signed [VALUE_WIDTH-1:0] edge_value;
    logic signed [VALUE_WIDTH-1:0] sample_value;
    logic [3:0]                    read_bin;

    assign req_type     = s_tuser;
    assign edge_index   = s_tdata[4:0];
    assign edge_value   = s_tdata[36:5];
    assign sample_value = s_tdata[68:37];
    assign read_bin     = s_tdata[72:69];

    // storage
    logic signed [VALUE_WIDTH-1:0] edges [MAX_BINS+1];
    logic [COUNT_WIDTH-1:0]        counts_reg [MAX_BINS];

    // control and working registers
    state_t                        state_reg, state_next;
    logic [4:0]                    bins_reg;
    logic [EDGE_IDX_W-1:0]         idx_reg, idx_next;
    logic [BIN_IDX_W-1:0]          hit_reg, hit_next;
    logic signed [VALUE_WIDTH-1:0] key_reg, key_next;

    logic                          m_valid_reg, m_valid_next;
    status_t                       m_status_reg, m_status_next;
    logic [3:0]                    m_bin_reg, m_bin_next;
    logic [31:0]                   m_count_reg, m_count_next;

    logic                          edge_we;
    logic                          count_we;
    logic [COUNT_WIDTH-1:0]        count_wdata;

    logic                          accept;
    logic                          out_free;
    logic [4:0]                    bins_active;
    logic signed [VALUE_WIDTH-1:0] edge_rd;
    logic [VALUE_WIDTH:0]          diff;
    logic                          key_lt;
    logic                          key_eq;
    logic [COUNT_WIDTH-1:0]        cnt_cur;
    logic [COUNT_WIDTH-1:0]        rd_count;

    assign out_free    = !m_valid_reg || m_tready;
    assign s_tready    = (state_reg == ST_IDLE) && out_free;
    assign accept      = s_tvalid && s_tready;
    assign bins_active = (bins_reg > 5'(MAX_BINS)) ? 5'(MAX_BINS) : bins_reg;

    // shared compare unit: one signed subtract against the selected edge
    assign edge_rd = (idx_reg <= EDGE_IDX_W'(MAX_BINS)) ? edges[idx_reg] : '0;
    assign diff    = {key_reg[VALUE_WIDTH-1], key_reg} - {edge_rd[VALUE_WIDTH-1], edge_rd};
    assign key_lt  = diff[VALUE_WIDTH];
    assign key_eq  = (diff == '0);

    assign cnt_cur  = counts_reg[hit_reg];
    assign rd_count = ({1'b0, read_bin} < 5'(MAX_BINS)) ?
                      counts_reg[read_bin[BIN_IDX_W-1:0]] : '0;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        hit_next      = hit_reg;
        key_next      = key_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_bin_next    = m_bin_reg;
        m_count_next  = m_count_reg;
        edge_we       = 1'b0;
        count_we      = 1'b0;
        count_wdata   = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + 1'b1;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        REQ_LOAD:
                        begin
                            edge_we       = (edge_index <= 5'(MAX_BINS));
                            m_valid_next  = 1'b1;
                            m_status_next = STAT_DONE;
                            m_bin_next    = '0;
                            m_count_next  = '0;
                        end
                        REQ_SAMPLE:
                        begin
                            key_next   = sample_value;
                            idx_next   = '0;
                            state_next = ST_SEARCH;
                        end
                        REQ_READ:
                        begin
                            m_valid_next  = 1'b1;
                            m_status_next = STAT_DONE;
                            m_bin_next    = read_bin;
                            m_count_next  = 32'(rd_count);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (idx_reg == '0)
                begin
                    if (key_lt)
                    begin
                        m_valid_next  = 1'b1;
                        m_status_next = STAT_BELOW;
                        m_bin_next    = '0;
                        m_count_next  = '0;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else if (5'(idx_reg) > bins_active)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = STAT_ABOVE;
                    m_bin_next    = '0;
                    m_count_next  = '0;
                    state_next    = ST_IDLE;
                end
                else if (key_lt || key_eq)
                begin
                    hit_next   = BIN_IDX_W'(idx_reg - 1'b1);
                    state_next = ST_UPDATE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_UPDATE:
            begin
                count_we      = 1'b1;
                m_valid_next  = 1'b1;
                m_status_next = STAT_COUNTED;
                m_bin_next    = 4'(hit_reg);
                m_count_next  = 32'(count_wdata);
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bins_reg    <= 5'd16;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_BINS; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                bins_reg <= cfg_wdata;
            end
            if (count_we)
            begin
                counts_reg[hit_reg] <= count_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        hit_reg      <= hit_next;
        key_reg      <= key_next;
        m_status_reg <= m_status_next;
        m_bin_reg    <= m_bin_next;
        m_count_reg  <= m_count_next;
        if (edge_we)
        begin
            edges[edge_index[EDGE_IDX_W-1:0]] <= edge_value;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {4'd0, m_count_reg, m_bin_reg};

endmodule
